>>> design/terminal_key_decoder_cursor_defines.svh
// Assertion macros used by the top level of the terminal key decoder.
`ifndef TERMINAL_KEY_DECODER_CURSOR_DEFINES_SVH
`define TERMINAL_KEY_DECODER_CURSOR_DEFINES_SVH

`ifndef SYNTHESIS

`define TKDC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

`define TKDC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define TKDC_ASSERT_SAME(name, clk, rst_n, ante, cons)

`define TKDC_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> design/tkd_pkg.sv
// Shared types and constants of the terminal key decoder.
`default_nettype none

package tkd_pkg;

    localparam int COORD_LIMIT = 1024;
    localparam int COORD_W     = 10;
    localparam int SIZE_W      = 11;
    localparam int KEY_W       = 9;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KEY_W-1:0] KEY_BS_CTRL = 9'd8;
    localparam logic [KEY_W-1:0] KEY_CR      = 9'd13;
    localparam logic [KEY_W-1:0] KEY_CTRL_Q  = 9'd17;
    localparam logic [KEY_W-1:0] KEY_CTRL_S  = 9'd19;
    localparam logic [KEY_W-1:0] KEY_ESC     = 9'd27;
    localparam logic [KEY_W-1:0] KEY_BS      = 9'd127;
    localparam logic [KEY_W-1:0] KEY_LEFT    = 9'd256;
    localparam logic [KEY_W-1:0] KEY_RIGHT   = 9'd257;
    localparam logic [KEY_W-1:0] KEY_UP      = 9'd258;
    localparam logic [KEY_W-1:0] KEY_DOWN    = 9'd259;
    localparam logic [KEY_W-1:0] KEY_DEL     = 9'd260;
    localparam logic [KEY_W-1:0] KEY_HOME    = 9'd261;
    localparam logic [KEY_W-1:0] KEY_END     = 9'd262;
    localparam logic [KEY_W-1:0] KEY_PGUP    = 9'd263;
    localparam logic [KEY_W-1:0] KEY_PGDN    = 9'd264;

    localparam logic [0:0] CFG_COLUMNS = 1'b0;
    localparam logic [0:0] CFG_ROWS    = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] code;
    } key_t;

    typedef struct packed {
        logic [COORD_W-1:0] col_last;
        logic [COORD_W-1:0] row_last;
        logic [SIZE_W-1:0]  rows;
    } geom_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

>>> design/tkd_front.sv
// Byte parser that turns escape sequences into key codes.
`default_nettype none

module tkd_front (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              byte_accept,
    input  wire [7:0]        in_byte,
    output tkd_pkg::key_t    key_out
);

    localparam logic [7:0] BYTE_ESC     = 8'h1b;
    localparam logic [7:0] BYTE_LSQUARE = 8'h5b;
    localparam logic [7:0] BYTE_SS3     = 8'h4f;
    localparam logic [7:0] BYTE_TILDE   = 8'h7e;
    localparam logic [7:0] BYTE_ZERO    = 8'h30;
    localparam logic [7:0] BYTE_NINE    = 8'h39;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_SEQ,
        PH_DIGIT
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [7:0]                  first_reg, first_next;
    logic [7:0]                  digit_reg, digit_next;
    logic                        emit;
    logic [tkd_pkg::KEY_W-1:0]   code;

    function automatic logic [tkd_pkg::KEY_W-1:0] letter_key(input logic [7:0] b,
                                                             input logic arrows);
        logic [tkd_pkg::KEY_W-1:0] k;
        k = tkd_pkg::KEY_ESC;
        unique case (b)
            8'h48: k = tkd_pkg::KEY_HOME;
            8'h46: k = tkd_pkg::KEY_END;
            8'h41: k = arrows ? tkd_pkg::KEY_UP : tkd_pkg::KEY_ESC;
            8'h42: k = arrows ? tkd_pkg::KEY_DOWN : tkd_pkg::KEY_ESC;
            8'h43: k = arrows ? tkd_pkg::KEY_RIGHT : tkd_pkg::KEY_ESC;
            8'h44: k = arrows ? tkd_pkg::KEY_LEFT : tkd_pkg::KEY_ESC;
            default: k = tkd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    function automatic logic [tkd_pkg::KEY_W-1:0] tilde_key(input logic [7:0] d);
        logic [tkd_pkg::KEY_W-1:0] k;
        k = tkd_pkg::KEY_ESC;
        unique case (d)
            8'h31, 8'h37: k = tkd_pkg::KEY_HOME;
            8'h33:        k = tkd_pkg::KEY_DEL;
            8'h34, 8'h38: k = tkd_pkg::KEY_END;
            8'h35:        k = tkd_pkg::KEY_PGUP;
            8'h36:        k = tkd_pkg::KEY_PGDN;
            default:      k = tkd_pkg::KEY_ESC;
        endcase
        return k;
    endfunction

    always_comb begin
        phase_next = phase_reg;
        first_next = first_reg;
        digit_next = digit_reg;
        emit       = 1'b0;
        code       = tkd_pkg::KEY_ESC;
        unique case (phase_reg)
            PH_IDLE: begin
                if (in_byte == BYTE_ESC) begin
                    phase_next = PH_ESC;
                end else begin
                    emit = 1'b1;
                    code = {1'b0, in_byte};
                end
            end
            PH_ESC: begin
                first_next = in_byte;
                phase_next = PH_SEQ;
            end
            PH_SEQ: begin
                phase_next = PH_IDLE;
                if (first_reg == BYTE_LSQUARE) begin
                    if (in_byte >= BYTE_ZERO && in_byte <= BYTE_NINE) begin
                        digit_next = in_byte;
                        phase_next = PH_DIGIT;
                    end else begin
                        emit = 1'b1;
                        code = letter_key(in_byte, 1'b1);
                    end
                end else if (first_reg == BYTE_SS3) begin
                    emit = 1'b1;
                    code = letter_key(in_byte, 1'b0);
                end else begin
                    emit = 1'b1;
                end
            end
            PH_DIGIT: begin
                phase_next = PH_IDLE;
                emit       = 1'b1;
                code       = (in_byte == BYTE_TILDE) ? tilde_key(digit_reg)
                                                     : tkd_pkg::KEY_ESC;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            first_reg <= 8'd0;
            digit_reg <= 8'd0;
        end else if (byte_accept) begin
            phase_reg <= phase_next;
            first_reg <= first_next;
            digit_reg <= digit_next;
        end
    end

    assign key_out.valid = byte_accept && emit;
    assign key_out.code  = code;

endmodule

`default_nettype wire

>>> design/tkd_queue.sv
// Short key queue between the parser and the cursor unit.
`default_nettype none

module tkd_queue (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire tkd_pkg::key_t           push_key,
    input  wire                          pop,
    output logic [tkd_pkg::KEY_W-1:0]    head_code,
    output tkd_pkg::queue_status_t       status
);

    logic [tkd_pkg::KEY_W-1:0]  slot_reg [tkd_pkg::QUEUE_DEPTH];
    logic [tkd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tkd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tkd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                       do_push, do_pop;

    assign do_push = push_key.valid && (count_reg != tkd_pkg::QCNT_W'(tkd_pkg::QUEUE_DEPTH));
    assign do_pop  = pop && (count_reg != '0);

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_key.code;
        end
    end

    assign head_code    = slot_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == tkd_pkg::QCNT_W'(tkd_pkg::QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> design/tkd_back.sv
// Cursor unit that applies each key and holds the result register.
`default_nettype none

module tkd_back (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          key_valid,
    input  wire [tkd_pkg::KEY_W-1:0]     key_code,
    input  wire tkd_pkg::geom_t          geom,
    output logic                         key_pop,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [31:0]                  m_tdata
);

    localparam logic [tkd_pkg::COORD_W-1:0] COORD_MAX =
        tkd_pkg::COORD_W'(tkd_pkg::COORD_LIMIT - 1);

    logic [tkd_pkg::COORD_W-1:0] col_reg, col_next;
    logic [tkd_pkg::COORD_W-1:0] row_reg, row_next;
    logic                        valid_reg;
    logic [31:0]                 data_reg, data_next;
    logic [tkd_pkg::COORD_W-1:0] col_right;
    logic [tkd_pkg::COORD_W-1:0] row_downstep;
    logic [tkd_pkg::SIZE_W:0]    row_jump;

    function automatic logic [tkd_pkg::COORD_W-1:0] step_up(
        input logic [tkd_pkg::COORD_W-1:0] v,
        input logic [tkd_pkg::COORD_W-1:0] last);
        return (v != last && v != COORD_MAX) ? v + 1'b1 : v;
    endfunction

    function automatic logic [tkd_pkg::COORD_W-1:0] step_down(
        input logic [tkd_pkg::COORD_W-1:0] v);
        return (v != '0) ? v - 1'b1 : v;
    endfunction

    assign key_pop      = key_valid && (!valid_reg || m_tready);
    assign col_right    = step_up(col_reg, geom.col_last);
    assign row_downstep = step_up(row_reg, geom.row_last);
    assign row_jump     = {2'b00, row_reg} + {1'b0, geom.rows};

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        case (key_code)
            tkd_pkg::KEY_CR, tkd_pkg::KEY_CTRL_Q, tkd_pkg::KEY_CTRL_S: begin
            end
            tkd_pkg::KEY_HOME:  col_next = '0;
            tkd_pkg::KEY_END:   col_next = geom.col_last;
            tkd_pkg::KEY_LEFT:  col_next = step_down(col_reg);
            tkd_pkg::KEY_RIGHT: col_next = col_right;
            tkd_pkg::KEY_UP:    row_next = step_down(row_reg);
            tkd_pkg::KEY_DOWN:  row_next = row_downstep;
            tkd_pkg::KEY_DEL:   col_next = step_down(col_right);
            tkd_pkg::KEY_BS, tkd_pkg::KEY_BS_CTRL: col_next = step_down(col_reg);
            tkd_pkg::KEY_PGUP: begin
                row_next = ({1'b0, row_reg} >= geom.rows)
                         ? tkd_pkg::COORD_W'({1'b0, row_reg} - geom.rows) : '0;
            end
            tkd_pkg::KEY_PGDN: begin
                if (row_reg < geom.row_last) begin
                    row_next = geom.row_last;
                end else if (row_reg > geom.row_last) begin
                    row_next = (row_jump > (tkd_pkg::SIZE_W + 1)'(COORD_MAX))
                             ? COORD_MAX : tkd_pkg::COORD_W'(row_jump);
                end
            end
            default: begin
                if (col_reg != COORD_MAX) begin
                    col_next = col_reg + 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        data_next = {(key_code == tkd_pkg::KEY_CTRL_S),
                     (key_code == tkd_pkg::KEY_CTRL_Q),
                     (key_code == tkd_pkg::KEY_CR),
                     row_next, col_next, key_code};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (key_pop) begin
                col_reg   <= col_next;
                row_reg   <= row_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (key_pop) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

`default_nettype wire

>>> design/terminal_key_decoder_cursor.sv
// Top level of the terminal key decoder with cursor tracking.
//
// Raw keyboard bytes enter on the s_ stream, one byte per transaction. Escape
// sequences are folded into single key codes; every byte that completes a key
// yields one transaction on the m_ stream with the key, the cursor column and
// row after that key, and the newline, quit and save flags.
// The cfg channel writes the screen size: index 0 sets the columns, index 1 the
// rows. It is always ready and should be written only while the block is idle.
// A byte that completes a key goes from the parser into a four-entry key queue,
// and its result reaches m_tvalid through the output register of the cursor unit.
// One byte is taken in every cycle while the queue is not full.
// When the receiver stalls, the result stays in the output register, the
// queue fills, and s_tready drops once the queue is full.
// Reset clears the parser, the cursor, the queue and the output, and restores
// 80 columns by 22 rows.
`default_nettype none

`include "terminal_key_decoder_cursor_defines.svh"

module terminal_key_decoder_cursor (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // in_byte[7:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // key_code[8:0], col_now[18:9], row_now[28:19],
                                   // newline_request[29], quit_request[30],
                                   // save_request[31]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [0:0]  cfg_index,
    input  wire  [10:0] cfg_data
);

    localparam logic [tkd_pkg::SIZE_W-1:0] SIZE_LIMIT =
        tkd_pkg::SIZE_W'(tkd_pkg::COORD_LIMIT);

    logic [tkd_pkg::SIZE_W-1:0]  cols_reg, cols_next;
    logic [tkd_pkg::SIZE_W-1:0]  rows_reg, rows_next;
    logic [tkd_pkg::SIZE_W-1:0]  cols_eff, rows_eff;
    tkd_pkg::geom_t              geom;
    tkd_pkg::key_t               parsed_key;
    tkd_pkg::queue_status_t      q_status;
    logic [tkd_pkg::KEY_W-1:0]   head_code;
    logic                        key_pop;
    logic                        byte_accept;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !q_status.full;
    assign byte_accept = s_tvalid && s_tready;

    always_comb begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_valid) begin
            if (cfg_index == tkd_pkg::CFG_COLUMNS) begin
                cols_next = cfg_data;
            end else begin
                rows_next = cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= 11'd80;
            rows_reg <= 11'd22;
        end else begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    assign cols_eff = (cols_reg == '0) ? 11'd1 : (cols_reg > SIZE_LIMIT ? SIZE_LIMIT : cols_reg);
    assign rows_eff = (rows_reg == '0) ? 11'd1 : (rows_reg > SIZE_LIMIT ? SIZE_LIMIT : rows_reg);

    assign geom.col_last = tkd_pkg::COORD_W'(cols_eff - 1'b1);
    assign geom.row_last = tkd_pkg::COORD_W'(rows_eff - 1'b1);
    assign geom.rows     = rows_eff;

    tkd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .in_byte     (s_tdata),
        .key_out     (parsed_key)
    );

    tkd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_key  (parsed_key),
        .pop       (key_pop),
        .head_code (head_code),
        .status    (q_status)
    );

    tkd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .key_valid (!q_status.empty),
        .key_code  (head_code),
        .geom      (geom),
        .key_pop   (key_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `TKDC_ASSERT_SAME(a_queue_bound, aclk, aresetn,
        1'b1, q_status.count <= tkd_pkg::QCNT_W'(tkd_pkg::QUEUE_DEPTH))

    `TKDC_ASSERT_NEXT(a_no_phantom_result, aclk, aresetn,
        !m_tvalid && q_status.empty, !m_tvalid)

    `TKDC_ASSERT_NEXT(a_queue_needs_byte, aclk, aresetn,
        q_status.empty && !(s_tvalid && s_tready), q_status.empty)

endmodule

`default_nettype wire

>>> tb/sv/key_cursor_checker.sv
// Checker that predicts and compares the key and cursor transactions of the terminal key decoder.
`timescale 1ns / 100ps

module key_cursor_checker (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    input  wire        s_tready,
    input  wire [7:0]  s_tdata,
    input  wire        m_tvalid,
    input  wire        m_tready,
    input  wire [31:0] m_tdata,
    input  wire        cfg_valid,
    input  wire        cfg_ready,
    input  wire [0:0]  cfg_index,
    input  wire [10:0] cfg_data,
    input  wire        run_done,
    output int         mismatch_count,
    output int         pending_keys
);

    import tkd_pkg::*;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_ONE      = 8'h31;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_FOUR     = 8'h34;
    localparam logic [7:0] CH_FIVE     = 8'h35;
    localparam logic [7:0] CH_SIX      = 8'h36;
    localparam logic [7:0] CH_SEVEN    = 8'h37;
    localparam logic [7:0] CH_EIGHT    = 8'h38;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_B  = 8'h42;
    localparam logic [7:0] CH_UPPER_C  = 8'h43;
    localparam logic [7:0] CH_UPPER_D  = 8'h44;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] CH_UPPER_H  = 8'h48;
    localparam logic [7:0] CH_UPPER_O  = 8'h4F;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_TILDE    = 8'h7E;

    typedef enum logic [1:0] {
        PARSE_IDLE,
        PARSE_ESC,
        PARSE_LEAD,
        PARSE_DIGIT
    } parse_state_e;

    // Same layout as m_tdata, highest field first.
    typedef struct packed {
        logic               save;
        logic               quit;
        logic               newline;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [KEY_W-1:0]   code;
    } key_report_t;

    parse_state_e      parse_state;
    logic [7:0]        lead_byte;
    logic [7:0]        held_digit;
    logic [SIZE_W-1:0] cols_reg;
    logic [SIZE_W-1:0] rows_reg;
    int                col_pos;
    int                row_pos;
    key_report_t       expected_keys[$];
    bit                leftover_flagged;

    function automatic int clamp_size(input logic [SIZE_W-1:0] v);
        if (v == 0) return 1;
        if (v > COORD_LIMIT) return COORD_LIMIT;
        return v;
    endfunction

    function automatic int step_fwd(input int v, input int size);
        if (v != size - 1 && v < COORD_LIMIT - 1) return v + 1;
        return v;
    endfunction

    function automatic int step_back(input int v);
        return (v != 0) ? v - 1 : 0;
    endfunction

    function automatic logic [KEY_W-1:0] letter_key(input logic [7:0] b, input bit arrows);
        if (b == CH_UPPER_H) return KEY_HOME;
        if (b == CH_UPPER_F) return KEY_END;
        if (arrows) begin
            if (b == CH_UPPER_A) return KEY_UP;
            if (b == CH_UPPER_B) return KEY_DOWN;
            if (b == CH_UPPER_C) return KEY_RIGHT;
            if (b == CH_UPPER_D) return KEY_LEFT;
        end
        return KEY_ESC;
    endfunction

    function automatic logic [KEY_W-1:0] tilde_key(input logic [7:0] d);
        case (d)
            CH_ONE, CH_SEVEN:  return KEY_HOME;
            CH_THREE:          return KEY_DEL;
            CH_FOUR, CH_EIGHT: return KEY_END;
            CH_FIVE:           return KEY_PGUP;
            CH_SIX:            return KEY_PGDN;
            default:           return KEY_ESC;
        endcase
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t key_cursor_checker: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic move_cursor(input logic [KEY_W-1:0] key);
        int cols;
        int rows;
        cols = clamp_size(cols_reg);
        rows = clamp_size(rows_reg);
        case (key)
            KEY_CR, KEY_CTRL_Q, KEY_CTRL_S: ;
            KEY_HOME:  col_pos = 0;
            KEY_END:   col_pos = cols - 1;
            KEY_LEFT:  col_pos = step_back(col_pos);
            KEY_RIGHT: col_pos = step_fwd(col_pos, cols);
            KEY_UP:    row_pos = step_back(row_pos);
            KEY_DOWN:  row_pos = step_fwd(row_pos, rows);
            KEY_DEL:   col_pos = step_back(step_fwd(col_pos, cols));
            KEY_BS, KEY_BS_CTRL: col_pos = step_back(col_pos);
            KEY_PGUP:  row_pos = (row_pos >= rows) ? row_pos - rows : 0;
            KEY_PGDN: begin
                if (row_pos < rows - 1) begin
                    row_pos = rows - 1;
                end else if (row_pos > rows - 1) begin
                    row_pos = (row_pos + rows > COORD_LIMIT - 1) ? COORD_LIMIT - 1
                                                                 : row_pos + rows;
                end
            end
            default: begin
                if (col_pos < COORD_LIMIT - 1) col_pos++;
            end
        endcase
    endtask

    task automatic decode_byte(input logic [7:0] b);
        logic [KEY_W-1:0] key;
        bit               complete;
        key_report_t      want;
        complete = 1'b1;
        key = {1'b0, b};
        case (parse_state)
            PARSE_IDLE: begin
                if (b == KEY_ESC[7:0]) begin
                    parse_state = PARSE_ESC;
                    complete = 1'b0;
                end
            end
            PARSE_ESC: begin
                lead_byte = b;
                parse_state = PARSE_LEAD;
                complete = 1'b0;
            end
            PARSE_LEAD: begin
                parse_state = PARSE_IDLE;
                if (lead_byte == CH_LBRACKET) begin
                    if (b >= CH_ZERO && b <= CH_NINE) begin
                        held_digit = b;
                        parse_state = PARSE_DIGIT;
                        complete = 1'b0;
                    end else begin
                        key = letter_key(b, 1'b1);
                    end
                end else if (lead_byte == CH_UPPER_O) begin
                    key = letter_key(b, 1'b0);
                end else begin
                    key = KEY_ESC;
                end
            end
            default: begin
                parse_state = PARSE_IDLE;
                key = (b == CH_TILDE) ? tilde_key(held_digit) : KEY_ESC;
            end
        endcase
        if (complete) begin
            move_cursor(key);
            want.code    = key;
            want.col     = col_pos[COORD_W-1:0];
            want.row     = row_pos[COORD_W-1:0];
            want.newline = (key == KEY_CR);
            want.quit    = (key == KEY_CTRL_Q);
            want.save    = (key == KEY_CTRL_S);
            expected_keys.push_back(want);
        end
    endtask

    task automatic compare_key(input key_report_t got);
        key_report_t want;
        if (expected_keys.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, data %h", got));
        end else begin
            want = expected_keys.pop_front();
            if (got.code != want.code)
                report_mismatch($sformatf("key_code %0d, want %0d", got.code, want.code));
            if (got.col != want.col)
                report_mismatch($sformatf("col_now %0d, want %0d", got.col, want.col));
            if (got.row != want.row)
                report_mismatch($sformatf("row_now %0d, want %0d", got.row, want.row));
            if (got.newline != want.newline)
                report_mismatch($sformatf("newline_request %0b, want %0b",
                                          got.newline, want.newline));
            if (got.quit != want.quit)
                report_mismatch($sformatf("quit_request %0b, want %0b", got.quit, want.quit));
            if (got.save != want.save)
                report_mismatch($sformatf("save_request %0b, want %0b", got.save, want.save));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_state      = PARSE_IDLE;
            lead_byte        = '0;
            held_digit       = '0;
            cols_reg         = SIZE_W'(80);
            rows_reg         = SIZE_W'(22);
            col_pos          = 0;
            row_pos          = 0;
            mismatch_count   = 0;
            leftover_flagged = 1'b0;
            expected_keys.delete();
            pending_keys <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_COLUMNS) cols_reg = cfg_data;
                else rows_reg = cfg_data;
            end
            if (m_tvalid && m_tready) compare_key(key_report_t'(m_tdata));
            if (s_tvalid && s_tready) decode_byte(s_tdata);
            if (run_done && !leftover_flagged && expected_keys.size() != 0) begin
                report_mismatch($sformatf("%0d keys never came out", expected_keys.size()));
                leftover_flagged = 1'b1;
            end
            pending_keys <= expected_keys.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
// Top of the terminal key decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;

    import tkd_pkg::*;

    localparam int IDLE_LIMIT    = 5000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 105;

    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_THREE    = 8'h33;
    localparam logic [7:0] CH_SIX      = 8'h36;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_B  = 8'h42;
    localparam logic [7:0] CH_UPPER_C  = 8'h43;
    localparam logic [7:0] CH_UPPER_D  = 8'h44;
    localparam logic [7:0] CH_UPPER_F  = 8'h46;
    localparam logic [7:0] CH_UPPER_H  = 8'h48;
    localparam logic [7:0] CH_UPPER_O  = 8'h4F;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_LOWER_X  = 8'h78;
    localparam logic [7:0] CH_TILDE    = 8'h7E;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [0:0]  cfg_index = CFG_COLUMNS;
    logic [10:0] cfg_data  = '0;
    logic        run_done  = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [31:0] m_tdata;
    wire         cfg_ready;

    int mismatch_count;
    int pending_keys;
    int tx_idle_pct = 30;
    int rx_idle_pct = 47;
    int quiet_cycles = 0;
    int bytes_sent = 0;

    terminal_key_decoder_cursor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    key_cursor_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .run_done       (run_done),
        .mismatch_count (mismatch_count),
        .pending_keys   (pending_keys)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Holds the input until every pending key has come out and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_keys != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_screen(input logic [10:0] cols, input logic [10:0] rows);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_COLUMNS;
        cfg_data  <= cols;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_random_key();
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            send_byte(KEY_ESC[7:0]);
            case ($urandom_range(2))
                0: begin
                    send_byte(CH_LBRACKET);
                    case ($urandom_range(5))
                        0: send_byte(CH_UPPER_A);
                        1: send_byte(CH_UPPER_B);
                        2: send_byte(CH_UPPER_C);
                        3: send_byte(CH_UPPER_D);
                        4: send_byte(CH_UPPER_H);
                        default: send_byte(CH_UPPER_F);
                    endcase
                end
                1: begin
                    send_byte(CH_UPPER_O);
                    send_byte($urandom_range(1) ? CH_UPPER_H : CH_UPPER_F);
                end
                default: begin
                    send_byte(CH_LBRACKET);
                    send_byte(CH_ZERO + 8'($urandom_range(9)));
                    send_byte(CH_TILDE);
                end
            endcase
        end else if (pick < 82) begin
            case ($urandom_range(7))
                0: send_byte(KEY_CR[7:0]);
                1: send_byte(KEY_CTRL_Q[7:0]);
                2: send_byte(KEY_CTRL_S[7:0]);
                3: send_byte(KEY_BS[7:0]);
                4: send_byte(KEY_BS_CTRL[7:0]);
                default: send_byte(8'($urandom_range(255)));
            endcase
        end else begin
            send_byte(KEY_ESC[7:0]);
            case ($urandom_range(3))
                0: begin
                    send_byte(8'($urandom_range(255)));
                    send_byte(8'($urandom_range(255)));
                end
                1: begin
                    send_byte(CH_LBRACKET);
                    send_byte(CH_ZERO + 8'($urandom_range(9)));
                    send_byte(8'($urandom_range(255)));
                end
                2: begin
                    send_byte(CH_LBRACKET);
                    send_byte(8'($urandom_range(255)));
                end
                default: begin
                    send_byte(CH_UPPER_O);
                    send_byte(8'($urandom_range(255)));
                end
            endcase
        end
    endtask

    initial begin
        logic [7:0]  directed_bytes[$];
        logic [10:0] cols;
        logic [10:0] rows;
        int          phase_end;
        int          phase_mid;
        bit          paused;

        directed_bytes = '{8'h00, 8'hFF, KEY_CR[7:0], KEY_CTRL_Q[7:0], KEY_CTRL_S[7:0],
                           KEY_BS[7:0], KEY_BS_CTRL[7:0],
                           KEY_ESC[7:0], CH_LBRACKET, CH_UPPER_C,
                           KEY_ESC[7:0], CH_UPPER_O, CH_UPPER_F,
                           KEY_ESC[7:0], CH_LBRACKET, CH_THREE, CH_TILDE,
                           KEY_ESC[7:0], CH_LBRACKET, CH_SIX, CH_TILDE,
                           KEY_ESC[7:0], CH_LOWER_X, CH_UPPER_A};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            if (phase < 2) begin
                tx_idle_pct = 30;
                rx_idle_pct = 47;
            end else if (phase < 4) begin
                tx_idle_pct = 47;
                rx_idle_pct = 30;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (phase)
                0: begin cols = 11'd2047; rows = 11'd2047; end
                1: begin cols = 11'd1024; rows = 11'd1024; end
                2: begin cols = 11'd3;    rows = 11'd2;    end
                3: begin cols = 11'd0;    rows = 11'd0;    end
                4: begin cols = 11'd1;    rows = 11'd1;    end
                default: begin
                    cols = 11'($urandom_range(1, 120));
                    rows = 11'($urandom_range(1, 60));
                end
            endcase
            set_screen(cols, rows);
            phase_end = bytes_sent + PHASE_ITEMS;
            phase_mid = bytes_sent + PHASE_ITEMS / 2;
            paused = 1'b0;
            while (bytes_sent < phase_end) begin
                if (!paused && bytes_sent >= phase_mid) begin
                    drain();
                    paused = 1'b1;
                end
                send_random_key();
            end
            drain();
        end

        run_done <= 1'b1;
        repeat (3) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
